[rtl/sce_pkg.sv]
// ----------------------------------------------------------------------------
// sce_pkg
// Shared constants and the exp table for the softmax cross-entropy block.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int MAX_VOCAB       = 4096;
  localparam int LOGIT_FRAC_BITS = 16;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int LOGIT_W  = 24;
  localparam int CFG_W    = 13;
  localparam int TOKEN_W  = 16;
  localparam int ARGMAX_W = 12;
  localparam int NLL_W    = 26;
  localparam int TOTAL_W  = 40;
  localparam int COUNT_W  = 32;
  localparam int ACC_W    = 29;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam logic [NLL_W-1:0]   NLL_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_TGT   = 1'b1;

  // 2^16 * 2^(-i/depth), alternating series of exp(-z) in Q0.32.
  function automatic logic [16:0] exp_entry(input int unsigned i, input int unsigned depth);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] diff;
    z = (64'(i) * 64'(LN2_Q32)) / 64'(depth);
    term = 64'd1 << 32;
    pos = term;
    neg = '0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * z) >> 32) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    diff = ((pos - neg) + 64'd32768) >> 16;
    return diff[16:0];
  endfunction

endpackage

[rtl/sce_ram.sv]
// ----------------------------------------------------------------------------
// sce_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sce_exp_rom.sv]
// ----------------------------------------------------------------------------
// sce_exp_rom
// Exp table 2^16 * 2^(-i/DEPTH) with a registered read.
// ----------------------------------------------------------------------------
module sce_exp_rom #(
  parameter int DEPTH = sce_pkg::EXP_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [16:0]              data
);

  logic [16:0] rom [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) rom[i] = sce_pkg::exp_entry(i, DEPTH);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

[rtl/softmax_cross_entropy_argmax.sv]
// ----------------------------------------------------------------------------
// softmax_cross_entropy_argmax
// Row-buffered softmax cross-entropy with first-wins argmax and batch totals.
// Sequence: load items are written to the row store; the last item of a finite
// row with a valid target starts an exp pass over the row, then normalize, log
// search and ln (normalize shifts at most 12 times); no input during the pass.
// Throughput: one item per cycle during load while no result is pending.
// Reset: synchronous, clears control state and totals; vocab_size = 4096.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_argmax #(
  parameter int MAX_VOCAB       = sce_pkg::MAX_VOCAB,
  parameter int EXP_TABLE_DEPTH = sce_pkg::EXP_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sce_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sce_pkg::LOGIT_W-1:0] logit,
  input  logic                              logit_nonfinite,
  input  logic [sce_pkg::TOKEN_W-1:0]       target_token,
  input  logic                              batch_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sce_pkg::ARGMAX_W-1:0]      row_argmax,
  output logic [sce_pkg::NLL_W-1:0]         row_nll,
  output logic                              row_finite,
  output logic [sce_pkg::TOTAL_W-1:0]       nll_total,
  output logic [sce_pkg::COUNT_W-1:0]       nonfinite_total,
  output logic                              status
);

  localparam int AW   = $clog2(MAX_VOCAB);
  localparam int CW   = AW + 1;
  localparam int TW   = $clog2(EXP_TABLE_DEPTH);
  localparam int F    = sce_pkg::LOGIT_FRAC_BITS;
  localparam int LW   = sce_pkg::LOGIT_W;
  localparam int DW   = LW + 1;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_MUL    = 10'b0000000100,
    S_TAB    = 10'b0000001000,
    S_ACC    = 10'b0000010000,
    S_NORM   = 10'b0000100000,
    S_LOGRD  = 10'b0001000000,
    S_LOGCMP = 10'b0010000000,
    S_LN     = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state;

  logic [sce_pkg::CFG_W-1:0] vocab_size;
  logic [CW-1:0]             len;
  logic [CW-1:0]             element_count;
  logic signed [LW-1:0]      running_max;
  logic [AW-1:0]             best_index;
  logic                      saw_nonfinite;
  logic [sce_pkg::TOKEN_W-1:0] row_target;
  logic [sce_pkg::ACC_W-1:0] exp_accumulator;
  logic [sce_pkg::TOTAL_W-1:0] batch_nll_sum;
  logic [sce_pkg::COUNT_W-1:0] batch_nonfinite_count;

  logic [CW-1:0]    scan_idx;
  logic             tgt_phase;
  logic [DW-1:0]    tgt_diff;
  logic [DW-1:0]    diff;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [5:0]       shift_n;
  logic [TW-1:0]    tab_idx;
  logic [16:0]      tab_data;
  logic [5:0]       k_shift;
  logic [sce_pkg::ACC_W-1:0] s_norm;
  logic [16:0]      m_val;
  logic [TW:0]      j_cnt;
  logic [TW:0]      log_i;

  logic [AW-1:0]    ram_wr_addr;
  logic [AW-1:0]    ram_rd_addr;
  logic signed [LW-1:0] ram_rd_data;
  logic             ram_wr_en;

  logic             in_fire;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    count_next;
  logic signed [LW-1:0] max_next;
  logic             nf_next;
  logic [sce_pkg::TOKEN_W-1:0] target_next;
  logic             row_done;

  always_comb begin
    if (vocab_size == '0) len = CW'(1);
    else if (32'(vocab_size) > MAX_VOCAB) len = CW'(MAX_VOCAB);
    else len = CW'(vocab_size);
  end

  assign cfg_ready = (state == S_LOAD) && !out_valid;
  assign in_ready  = (state == S_LOAD) && !out_valid;
  assign in_fire   = in_valid && in_ready;
  assign pos       = element_count[AW-1:0];
  assign count_next = element_count + CW'(1);
  assign row_done  = count_next >= len;

  always_comb begin
    if (element_count == '0) begin
      max_next    = logit;
      nf_next     = logit_nonfinite;
      target_next = target_token;
    end else begin
      max_next    = (logit > running_max) ? logit : running_max;
      nf_next     = saw_nonfinite | logit_nonfinite;
      target_next = row_target;
    end
  end

  assign ram_wr_en   = in_fire;
  assign ram_wr_addr = pos;
  assign ram_rd_addr = tgt_phase ? row_target[AW-1:0] : scan_idx[AW-1:0];

  sce_ram #(.WIDTH(LW), .DEPTH(MAX_VOCAB)) u_row_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (logit),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sce_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_exp_rom (
    .clk  (clk),
    .addr (tab_idx),
    .data (tab_data)
  );

  assign diff = DW'(running_max) - DW'(ram_rd_data);
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL:    begin mul_a = 32'(diff); mul_b = 32'(sce_pkg::LOG2E_Q30); end
      S_LOGCMP: begin mul_a = 32'(m_val); mul_b = 32'(tab_data); end
      S_LN: begin
        mul_a = 32'({k_shift, F'(0)}) + 32'((32'(j_cnt) << F) >> TW);
        mul_b = 32'(sce_pkg::LN2_Q30);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_LOAD;
      vocab_size            <= sce_pkg::CFG_W'(4096);
      element_count         <= '0;
      running_max           <= '0;
      best_index            <= '0;
      saw_nonfinite         <= 1'b0;
      row_target            <= '0;
      exp_accumulator       <= '0;
      batch_nll_sum         <= '0;
      batch_nonfinite_count <= '0;
      out_valid             <= 1'b0;
      tgt_phase             <= 1'b0;
      scan_idx              <= '0;
      k_shift               <= '0;
      s_norm                <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) vocab_size <= cfg_data;
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (element_count == '0) begin
              best_index <= '0;
              if (batch_start) begin
                batch_nll_sum         <= '0;
                batch_nonfinite_count <= '0;
              end
            end else if (logit > running_max) begin
              best_index <= pos;
            end
            running_max   <= max_next;
            saw_nonfinite <= nf_next;
            row_target    <= target_next;
            if (row_done) begin
              element_count <= '0;
              row_argmax    <= (element_count != '0 && logit > running_max) ?
                               sce_pkg::ARGMAX_W'(pos) :
                               ((element_count == '0) ? '0 :
                                sce_pkg::ARGMAX_W'(best_index));
              row_finite    <= !nf_next;
              if (32'(target_next) >= 32'(len)) begin
                status    <= sce_pkg::STATUS_BAD_TGT;
                row_nll   <= '0;
                nll_total <= (element_count == '0 && batch_start) ? '0 : batch_nll_sum;
                nonfinite_total <= (element_count == '0 && batch_start) ? '0 :
                                   batch_nonfinite_count;
                out_valid <= 1'b1;
              end else if (nf_next) begin
                status  <= sce_pkg::STATUS_OK;
                row_nll <= '0;
                nll_total <= (element_count == '0 && batch_start) ? '0 : batch_nll_sum;
                if (element_count == '0 && batch_start) begin
                  batch_nonfinite_count <= sce_pkg::COUNT_W'(1);
                  nonfinite_total       <= sce_pkg::COUNT_W'(1);
                end else if (batch_nonfinite_count != sce_pkg::COUNT_MAX) begin
                  batch_nonfinite_count <= batch_nonfinite_count + 1'b1;
                  nonfinite_total       <= batch_nonfinite_count + 1'b1;
                end else begin
                  nonfinite_total <= batch_nonfinite_count;
                end
                out_valid <= 1'b1;
              end else begin
                status          <= sce_pkg::STATUS_OK;
                exp_accumulator <= '0;
                scan_idx        <= '0;
                tgt_phase       <= 1'b0;
                state           <= S_RD;
              end
            end else begin
              element_count <= count_next;
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          shift_n <= (prod[63:30] >> F) > 34'd32 ? 6'd32 : 6'(prod[63:30] >> F);
          tab_idx <= TW'((64'(prod[30 +: F]) * 64'(EXP_TABLE_DEPTH)) >> F);
          if (tgt_phase) begin
            tgt_diff <= diff;
            state    <= S_NORM;
          end else begin
            state <= S_TAB;
          end
        end
        S_TAB: state <= S_ACC;
        S_ACC: begin
          if (shift_n < 6'd32) begin
            if (30'(exp_accumulator) + 30'(tab_data >> shift_n) > 30'(sce_pkg::ACC_MAX))
              exp_accumulator <= sce_pkg::ACC_MAX;
            else
              exp_accumulator <= exp_accumulator + sce_pkg::ACC_W'(tab_data >> shift_n);
          end
          if (scan_idx + CW'(1) >= len) tgt_phase <= 1'b1;
          scan_idx <= scan_idx + CW'(1);
          state    <= S_RD;
        end
        S_NORM: begin
          if (k_shift == '0 && s_norm == '0) begin
            s_norm  <= (exp_accumulator < sce_pkg::ACC_W'(65536)) ?
                       sce_pkg::ACC_W'(65536) : exp_accumulator;
            k_shift <= 6'd1;
          end else if (s_norm >= sce_pkg::ACC_W'(131072)) begin
            s_norm  <= s_norm >> 1;
            k_shift <= k_shift + 6'd1;
          end else begin
            k_shift <= k_shift - 6'd1;
            m_val   <= s_norm[16:0];
            j_cnt   <= '0;
            log_i   <= (TW+1)'(1);
            tab_idx <= TW'(1);
            state   <= (EXP_TABLE_DEPTH > 1) ? S_LOGRD : S_LN;
          end
        end
        S_LOGRD: state <= S_LOGCMP;
        S_LOGCMP: begin
          if (prod >= (64'd1 << 32)) j_cnt <= j_cnt + 1'b1;
          if (32'(log_i) + 1 >= EXP_TABLE_DEPTH) begin
            state <= S_LN;
          end else begin
            log_i   <= log_i + 1'b1;
            tab_idx <= TW'(log_i + 1'b1);
            state   <= S_LOGRD;
          end
        end
        S_LN: begin
          if (64'((prod + (64'd1 << 29)) >> 30) + 64'(tgt_diff) > 64'(sce_pkg::NLL_MAX)) begin
            row_nll <= sce_pkg::NLL_MAX;
            if (41'(batch_nll_sum) + 41'(sce_pkg::NLL_MAX) > 41'(sce_pkg::TOTAL_MAX)) begin
              batch_nll_sum <= sce_pkg::TOTAL_MAX;
              nll_total     <= sce_pkg::TOTAL_MAX;
            end else begin
              batch_nll_sum <= batch_nll_sum + sce_pkg::TOTAL_W'(sce_pkg::NLL_MAX);
              nll_total     <= batch_nll_sum + sce_pkg::TOTAL_W'(sce_pkg::NLL_MAX);
            end
          end else begin
            row_nll <= sce_pkg::NLL_W'(((prod + (64'd1 << 29)) >> 30) + 64'(tgt_diff));
            if (41'(batch_nll_sum) + 41'(((prod + (64'd1 << 29)) >> 30) + 64'(tgt_diff))
                > 41'(sce_pkg::TOTAL_MAX)) begin
              batch_nll_sum <= sce_pkg::TOTAL_MAX;
              nll_total     <= sce_pkg::TOTAL_MAX;
            end else begin
              batch_nll_sum <= batch_nll_sum +
                sce_pkg::TOTAL_W'(((prod + (64'd1 << 29)) >> 30) + 64'(tgt_diff));
              nll_total <= batch_nll_sum +
                sce_pkg::TOTAL_W'(((prod + (64'd1 << 29)) >> 30) + 64'(tgt_diff));
            end
          end
          nonfinite_total <= batch_nonfinite_count;
          k_shift   <= '0;
          s_norm    <= '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          tgt_phase <= 1'b0;
          state     <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
